FILE: sv/first_fit_block_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define FFBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

  // Free-map word: blocks held per memory word
  localparam int WORD_W     = 8;
  localparam int WORD_SHIFT = 3;

  // Field widths
  localparam int TYPE_W  = 1;
  localparam int COUNT_W = 11;
  localparam int START_W = 10;
  localparam int STAT_W  = 2;

  // Request kinds
  localparam logic [TYPE_W-1:0] REQ_ALLOC = 1'b0;
  localparam logic [TYPE_W-1:0] REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK,
    ST_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr_step;
    logic scan_first;
    logic scan_step;
    logic mark_first;
    logic mark_step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic req_alloc;
    logic count_zero;
    logic range_bad;
    logic found;
    logic scan_last;
    logic mark_last;
  } sts_t;

endpackage

FILE: sv/ffba_ctrl.sv
// Sequencer of the allocator: clearing pass, scan and mark phases, result beat.
module ffba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);

  ffba_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffba_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ffba_pkg::ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ffba_pkg::ST_DECIDE;
        end
      end
      ffba_pkg::ST_DECIDE: begin
        if (sts.req_alloc) begin
          state_next = sts.count_zero ? ffba_pkg::ST_RESP : ffba_pkg::ST_SCAN_RD;
        end else begin
          state_next = (sts.count_zero || sts.range_bad) ? ffba_pkg::ST_RESP
                                                          : ffba_pkg::ST_MARK_RD;
        end
      end
      ffba_pkg::ST_SCAN_RD: begin
        cmd.scan_first = 1'b1;
        state_next     = ffba_pkg::ST_SCAN;
      end
      ffba_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found) begin
          state_next = ffba_pkg::ST_MARK_RD;
        end else if (sts.scan_last) begin
          state_next = ffba_pkg::ST_RESP;
        end
      end
      ffba_pkg::ST_MARK_RD: begin
        cmd.mark_first = 1'b1;
        state_next     = ffba_pkg::ST_MARK;
      end
      ffba_pkg::ST_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) state_next = ffba_pkg::ST_RESP;
      end
      ffba_pkg::ST_RESP: begin
        done       = 1'b1;
        state_next = ffba_pkg::ST_IDLE;
      end
      default: begin
        state_next = ffba_pkg::ST_INIT;
      end
    endcase
  end

endmodule

FILE: sv/ffba_dp.sv
// Datapath of the allocator: free-map memory, run scanner and range marker.
module ffba_dp #(
  parameter int MAP_SIZE = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ffba_pkg::cmd_t                 cmd,
  input  logic [ffba_pkg::TYPE_W-1:0]    req_type,
  input  logic [ffba_pkg::COUNT_W-1:0]   block_count,
  input  logic [ffba_pkg::START_W-1:0]   free_start,
  output ffba_pkg::sts_t                 sts,
  output logic [ffba_pkg::STAT_W-1:0]    status,
  output logic [ffba_pkg::START_W-1:0]   run_start
);

  localparam int NUM_WORDS = (MAP_SIZE + ffba_pkg::WORD_W - 1) / ffba_pkg::WORD_W;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int POS_W     = WADDR_W + ffba_pkg::WORD_SHIFT;
  localparam int RUN_W     = ($clog2(MAP_SIZE + 1) > ffba_pkg::COUNT_W) ?
                             $clog2(MAP_SIZE + 1) : ffba_pkg::COUNT_W;
  localparam int SUM_W     = RUN_W + 1;
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);
  localparam logic [SUM_W-1:0]   LIMIT     = SUM_W'(MAP_SIZE);

  // Free map, one bit per block, 1 means free
  logic [ffba_pkg::WORD_W-1:0] mem [NUM_WORDS];
  logic [ffba_pkg::WORD_W-1:0] rdata;
  logic [ffba_pkg::WORD_W-1:0] wdata;
  logic [WADDR_W-1:0]          waddr;
  logic [WADDR_W-1:0]          raddr;
  logic                        we;

  // Request and walk registers
  logic [ffba_pkg::TYPE_W-1:0]  type_q;
  logic [ffba_pkg::COUNT_W-1:0] cnt_q;
  logic [POS_W-1:0]             lo_q;
  logic                         fill_q;
  logic [ffba_pkg::STAT_W-1:0]  status_q;
  logic [POS_W-1:0]             start_q;
  logic [WADDR_W-1:0]           cur_idx;
  logic [WADDR_W-1:0]           clr_idx;
  logic [RUN_W-1:0]             run_q;
  logic [POS_W-1:0]             cand_q;

  // Scan and mark combinational values
  logic [RUN_W-1:0]             run_v;
  logic [POS_W-1:0]             cand_v;
  logic                         hit;
  logic [RUN_W-1:0]             cnt_ext;
  logic [SUM_W-1:0]             hi;
  logic [WADDR_W-1:0]           hi_word;
  logic [ffba_pkg::WORD_W-1:0]  mark_mask;
  logic [ffba_pkg::WORD_W-1:0]  clr_mask;
  logic [SUM_W-1:0]             pos_mark;
  logic [SUM_W-1:0]             pos_clr;
  logic [WADDR_W-1:0]           next_idx;
  logic                         range_bad_in;

  assign cnt_ext  = RUN_W'(cnt_q);
  assign hi       = SUM_W'(lo_q) + SUM_W'(cnt_q);
  assign hi_word  = WADDR_W'((hi - SUM_W'(1)) >> ffba_pkg::WORD_SHIFT);
  assign next_idx = (cur_idx == LAST_WORD) ? cur_idx : cur_idx + WADDR_W'(1);
  assign range_bad_in = (SUM_W'(free_start) + SUM_W'(block_count)) > LIMIT;

  // Walk one word: extend the current free run bit by bit, stop at first fit
  always_comb begin
    run_v  = run_q;
    cand_v = cand_q;
    hit    = 1'b0;
    for (int j = 0; j < ffba_pkg::WORD_W; j++) begin
      if (!hit) begin
        if (rdata[j]) begin
          if (run_v == '0) cand_v = {cur_idx, ffba_pkg::WORD_SHIFT'(j)};
          run_v = run_v + RUN_W'(1);
          if (run_v == cnt_ext) hit = 1'b1;
        end else begin
          run_v = '0;
        end
      end
    end
  end

  // Build masks for the marked range and for the clearing pass
  always_comb begin
    mark_mask = '0;
    clr_mask  = '0;
    pos_mark  = '0;
    pos_clr   = '0;
    for (int j = 0; j < ffba_pkg::WORD_W; j++) begin
      pos_mark     = SUM_W'({cur_idx, ffba_pkg::WORD_SHIFT'(j)});
      pos_clr      = SUM_W'({clr_idx, ffba_pkg::WORD_SHIFT'(j)});
      mark_mask[j] = (pos_mark >= SUM_W'(lo_q)) && (pos_mark < hi);
      clr_mask[j]  = pos_clr < LIMIT;
    end
  end

  // Select memory write and read addresses
  always_comb begin
    we    = 1'b0;
    waddr = clr_idx;
    wdata = clr_mask;
    raddr = cur_idx;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.mark_step) begin
      we    = 1'b1;
      waddr = cur_idx;
      wdata = fill_q ? (rdata | mark_mask) : (rdata & ~mark_mask);
    end
    if (cmd.scan_first) begin
      raddr = '0;
    end else if (cmd.mark_first) begin
      raddr = WADDR_W'(lo_q >> ffba_pkg::WORD_SHIFT);
    end else if (cmd.scan_step || cmd.mark_step) begin
      raddr = next_idx;
    end
  end

  // Memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step && (clr_idx != LAST_WORD)) begin
      clr_idx <= clr_idx + WADDR_W'(1);
    end
  end

  // Capture the request, track the walk and the result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_q   <= req_type;
      cnt_q    <= block_count;
      lo_q     <= POS_W'(free_start);
      fill_q   <= (req_type == ffba_pkg::REQ_FREE);
      start_q  <= '0;
      status_q <= ((req_type == ffba_pkg::REQ_FREE) && range_bad_in) ?
                  ffba_pkg::STAT_RANGE : ffba_pkg::STAT_OK;
    end
    if (cmd.scan_first || cmd.mark_first) begin
      cur_idx <= raddr;
    end else if (cmd.scan_step || cmd.mark_step) begin
      cur_idx <= next_idx;
    end
    if (cmd.scan_first) begin
      run_q  <= '0;
      cand_q <= '0;
    end else if (cmd.scan_step) begin
      run_q  <= run_v;
      cand_q <= cand_v;
      if (hit) begin
        start_q <= cand_v;
        lo_q    <= cand_v;
        fill_q  <= 1'b0;
      end else if (cur_idx == LAST_WORD) begin
        status_q <= ffba_pkg::STAT_NO_SPACE;
      end
    end
  end

  // Status to the controller
  assign sts.clr_last   = (clr_idx == LAST_WORD);
  assign sts.req_alloc  = (type_q == ffba_pkg::REQ_ALLOC);
  assign sts.count_zero = (cnt_q == '0);
  assign sts.range_bad  = (status_q == ffba_pkg::STAT_RANGE);
  assign sts.found      = hit;
  assign sts.scan_last  = (cur_idx == LAST_WORD);
  assign sts.mark_last  = (cur_idx == hi_word);

  assign status    = status_q;
  assign run_start = ffba_pkg::START_W'(start_q);

endmodule

FILE: sv/first_fit_block_allocator.sv
// Top level of the first-fit contiguous block allocator.
// The free map sits in a memory of 8-block words. After reset busy stays high
// during a clearing pass that marks every block free.
// A request is taken when start is high and busy is low. An allocate walks
// the map from block 0 at one word (8 blocks) per cycle, as the memory has a
// single read port; the walk stops at the first word where a run fits, then
// the words the run covers are marked, and the result beat follows. When no
// run fits, the walk goes on to the last word of the map. A free reads and
// marks the words of its range; an out-of-range free or a zero count goes
// straight to the result beat. busy drops in the cycle after the result beat,
// so the next request is taken in that cycle at the earliest.
// The result beat (status, run_start) is shown for exactly one cycle with done
// high; the receiver cannot stall it and must take it in that cycle.
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator #(
  parameter int MAP_SIZE = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffba_pkg::TYPE_W-1:0]   req_type,
  input  logic [ffba_pkg::COUNT_W-1:0]  block_count,
  input  logic [ffba_pkg::START_W-1:0]  free_start,
  output logic                          done,
  output logic [ffba_pkg::STAT_W-1:0]   status,
  output logic [ffba_pkg::START_W-1:0]  run_start
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  // Sequencer
  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Free map and scan datapath
  ffba_dp #(
    .MAP_SIZE (MAP_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req_type),
    .block_count (block_count),
    .free_start  (free_start),
    .sts         (sts),
    .status      (status),
    .run_start   (run_start)
  );

  // A failed request reports no run start
  `FFBA_ASSERT_SAME(a_fail_start_zero, clk, rst, done && (status != ffba_pkg::STAT_OK), run_start == '0, "failed request reports a nonzero run start")
  // An accepted request keeps the block busy in the next cycle
  `FFBA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "block not busy after accepting a request")
  // A result beat lasts one cycle and the block is ready right after it
  `FFBA_ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy, "result beat longer than one cycle")
  // The datapath never both clears and marks
  `FFBA_ASSERT_SAME(a_cmd_excl, clk, rst, cmd.clr_step || cmd.mark_step, !(cmd.clr_step && cmd.mark_step), "clearing and marking at once")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the first-fit block allocator: directed table, then random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_SIZE     = 1024;
  localparam int RANDOM_ITEMS = 1350;
  localparam int TAIL_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_ROWS     = 25;

  // One directed request; pinned rows carry a hand-read reply
  typedef struct packed {
    logic [ffba_pkg::TYPE_W-1:0]  kind;
    logic [ffba_pkg::COUNT_W-1:0] count;
    logic [ffba_pkg::START_W-1:0] first;
    logic                         pinned;
    logic [ffba_pkg::STAT_W-1:0]  status;
    logic [ffba_pkg::START_W-1:0] run_start;
  } stim_row_t;

  typedef struct packed {
    logic [ffba_pkg::STAT_W-1:0]  status;
    logic [ffba_pkg::START_W-1:0] run_start;
  } reply_t;

  // Run of blocks currently held by an earlier allocate
  typedef struct packed {
    logic [ffba_pkg::START_W-1:0] first;
    logic [ffba_pkg::COUNT_W-1:0] count;
  } run_t;

  localparam stim_row_t [0:DIR_ROWS-1] DIRECTED_ROWS = '{
    '{ffba_pkg::REQ_ALLOC, 11'd1,    10'd0,    1'b1, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd0,    10'd0,    1'b1, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd1024, 10'd0,    1'b1, ffba_pkg::STAT_NO_SPACE, 10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd2047, 10'd1023, 1'b1, ffba_pkg::STAT_NO_SPACE, 10'd0},
    '{ffba_pkg::REQ_FREE,  11'd1,    10'd0,    1'b1, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd1024, 10'd0,    1'b1, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd1,    10'd0,    1'b1, ffba_pkg::STAT_NO_SPACE, 10'd0},
    '{ffba_pkg::REQ_FREE,  11'd1,    10'd1023, 1'b1, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd1,    10'd0,    1'b1, ffba_pkg::STAT_OK,       10'd1023},
    '{ffba_pkg::REQ_FREE,  11'd2,    10'd1023, 1'b1, ffba_pkg::STAT_RANGE,    10'd0},
    '{ffba_pkg::REQ_FREE,  11'd1025, 10'd0,    1'b1, ffba_pkg::STAT_RANGE,    10'd0},
    '{ffba_pkg::REQ_FREE,  11'd0,    10'd1023, 1'b1, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_FREE,  11'd1024, 10'd0,    1'b1, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_FREE,  11'd5,    10'd100,  1'b0, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd10,   10'd1023, 1'b0, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd20,   10'd0,    1'b0, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd5,    10'd0,    1'b0, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_FREE,  11'd20,   10'd10,   1'b0, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd21,   10'd0,    1'b0, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd15,   10'd0,    1'b0, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_ALLOC, 11'd5,    10'd0,    1'b0, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_FREE,  11'd30,   10'd1000, 1'b1, ffba_pkg::STAT_RANGE,    10'd0},
    '{ffba_pkg::REQ_FREE,  11'd2047, 10'd512,  1'b1, ffba_pkg::STAT_RANGE,    10'd0},
    '{ffba_pkg::REQ_FREE,  11'd1,    10'd1023, 1'b0, ffba_pkg::STAT_OK,       10'd0},
    '{ffba_pkg::REQ_FREE,  11'd1024, 10'd0,    1'b1, ffba_pkg::STAT_OK,       10'd0}
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [ffba_pkg::TYPE_W-1:0]  req_type = ffba_pkg::REQ_ALLOC;
  logic [ffba_pkg::COUNT_W-1:0] block_count = '0;
  logic [ffba_pkg::START_W-1:0] free_start = '0;
  logic                         busy;
  logic                         done;
  logic [ffba_pkg::STAT_W-1:0]  status;
  logic [ffba_pkg::START_W-1:0] run_start;

  logic   free_map [MAP_SIZE];  // 1 = block free
  reply_t pending_replies [$];
  run_t   live_runs [$];
  int     fault_count = 0;
  int     idle_pct = 23;

  first_fit_block_allocator #(
    .MAP_SIZE(MAP_SIZE)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .block_count (block_count),
    .free_start  (free_start),
    .done        (done),
    .status      (status),
    .run_start   (run_start)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow free map and return the reply it earns
  function automatic reply_t apply_request(logic [ffba_pkg::TYPE_W-1:0] kind, int count,
                                           int first);
    reply_t r;
    int     run_len;
    int     cand;
    r.status    = ffba_pkg::STAT_OK;
    r.run_start = '0;
    run_len     = 0;
    cand        = 0;
    if (kind == ffba_pkg::REQ_ALLOC) begin
      if (count != 0) begin
        // first fit: stop at the first free run that reaches the count
        for (int i = 0; i < MAP_SIZE; i++) begin
          if (!free_map[i]) begin
            run_len = 0;
          end else begin
            if (run_len == 0) cand = i;
            run_len++;
            if (run_len == count) break;
          end
        end
        if (run_len == count) begin
          for (int i = cand; i < cand + count; i++) free_map[i] = 1'b0;
          r.run_start = cand[ffba_pkg::START_W-1:0];
        end else begin
          r.status = ffba_pkg::STAT_NO_SPACE;
        end
      end
    end else if (first + count > MAP_SIZE) begin
      r.status = ffba_pkg::STAT_RANGE;
    end else begin
      for (int i = first; i < first + count; i++) free_map[i] = 1'b1;
    end
    return r;
  endfunction

  function automatic int alloc_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 2) return 0;
    if (pick < 70) return $urandom_range(16, 1);
    if (pick < 90) return $urandom_range(128, 17);
    if (pick < 97) return $urandom_range(1024, 129);
    return $urandom_range(2047, 1025);
  endfunction

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Drive one request beat, wait for the handshake, then log the expected reply
  task automatic send_request(logic [ffba_pkg::TYPE_W-1:0] kind, int count, int first,
                              logic pinned, reply_t pinned_reply);
    reply_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= kind;
    block_count <= count[ffba_pkg::COUNT_W-1:0];
    free_start  <= first[ffba_pkg::START_W-1:0];
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_request(kind, count, first);
    pending_replies.push_back(pinned ? pinned_reply : predicted);
    if (kind == ffba_pkg::REQ_ALLOC && count != 0 && predicted.status == ffba_pkg::STAT_OK)
      live_runs.push_back('{first: predicted.run_start,
                            count: count[ffba_pkg::COUNT_W-1:0]});
  endtask

  // Hold off the sender until every outstanding reply has come back
  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // Mostly allocate and release held runs; mix in stray, partial and bad frees
  task automatic send_random_request();
    int   pick;
    int   count;
    int   first;
    int   idx;
    run_t victim;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_request(ffba_pkg::REQ_ALLOC, alloc_size(), $urandom_range(MAP_SIZE - 1), 1'b0, '0);
    end else if (pick < 80 && live_runs.size() != 0) begin
      idx    = $urandom_range(live_runs.size() - 1);
      victim = live_runs[idx];
      live_runs.delete(idx);
      first  = victim.first;
      count  = victim.count;
      // now and then release only part of the run; the rest leaks until a full clear
      if ($urandom_range(4) == 0) begin
        first = first + $urandom_range(count - 1);
        count = $urandom_range(victim.first + victim.count - first);
      end
      send_request(ffba_pkg::REQ_FREE, count, first, 1'b0, '0);
    end else if (pick < 92) begin
      first = $urandom_range(MAP_SIZE - 1);
      count = $urandom_range((MAP_SIZE - first < 64) ? MAP_SIZE - first : 64);
      send_request(ffba_pkg::REQ_FREE, count, first, 1'b0, '0);
    end else if (pick < 98) begin
      first = $urandom_range(MAP_SIZE - 1);
      count = $urandom_range(2047, MAP_SIZE - first + 1);
      send_request(ffba_pkg::REQ_FREE, count, first, 1'b0, '0);
    end else begin
      live_runs.delete();
      send_request(ffba_pkg::REQ_FREE, MAP_SIZE, 0, 1'b0, '0);
    end
  endtask

  // Match every reply beat against the oldest outstanding expectation
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_replies.size() == 0) begin
        note_fault($sformatf("unexpected reply beat: status %0d run_start %0d",
                             status, run_start));
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status || run_start !== want.run_start)
          note_fault($sformatf({"reply mismatch: status exp %0d got %0d, ",
                                "run_start exp %0d got %0d"},
                               want.status, status, want.run_start, run_start));
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        phase_idle [3];
    phase_idle = '{23, 57, 0};
    foreach (free_map[i]) free_map[i] = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      send_request(row.kind, row.count, row.first, row.pinned, '{row.status, row.run_start});
    end
    drain_replies();
    live_runs.delete();

    // random traffic, one idling profile per phase
    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_random_request();
      drain_replies();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
